@@ hw/rtl/bsm_pkg.sv @@
// Shared types, constants and codes for the bank switch mapper.
`default_nettype none
package bsm_pkg;

  localparam int PRG_ADDR_BITS = 19;
  localparam int CHR_ADDR_BITS = 18;

  localparam int BANK_N     = 8;
  localparam int BANK_IDX_W = $clog2(BANK_N);

  localparam logic [20:0] PRG_MASK = 21'((64'd1 << PRG_ADDR_BITS) - 64'd1);
  localparam logic [19:0] CHR_MASK = 20'((64'd1 << CHR_ADDR_BITS) - 64'd1);

  // actions
  localparam logic [2:0] ACT_PRG_RD = 3'd0;
  localparam logic [2:0] ACT_PRG_WR = 3'd1;
  localparam logic [2:0] ACT_CHR_RD = 3'd2;
  localparam logic [2:0] ACT_CHR_WR = 3'd3;
  localparam logic [2:0] ACT_TICK   = 3'd4;
  localparam logic [2:0] ACT_NT     = 3'd5;

  // targets
  localparam logic [2:0] TGT_NONE    = 3'd0;
  localparam logic [2:0] TGT_PRG_ROM = 3'd1;
  localparam logic [2:0] TGT_PRG_RAM = 3'd2;
  localparam logic [2:0] TGT_CHR_ROM = 3'd3;
  localparam logic [2:0] TGT_CHR_RAM = 3'd4;
  localparam logic [2:0] TGT_NT_RAM  = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_PRG_UNITS = 2'd0;
  localparam logic [1:0] CFG_CHR_UNITS = 2'd1;
  localparam logic [1:0] CFG_CHR_RAM   = 2'd2;

  // bus windows and mapper ports
  localparam logic [15:0] PRG_RAM_BASE = 16'h6000;
  localparam logic [15:0] PRG_ROM_BASE = 16'h8000;
  localparam logic [15:0] PORT_MASK    = 16'hE001;
  localparam logic [15:0] PORT_SELECT  = 16'h8000;
  localparam logic [15:0] PORT_BANK    = 16'h8001;
  localparam logic [15:0] PORT_MIRROR  = 16'hA000;
  localparam logic [15:0] PORT_LATCH   = 16'hC000;
  localparam logic [15:0] PORT_RELOAD  = 16'hC001;
  localparam logic [15:0] PORT_IRQ_OFF = 16'hE000;
  localparam logic [15:0] PORT_IRQ_ON  = 16'hE001;

  localparam logic [BANK_IDX_W-1:0] BANK_FIXED_IDX = BANK_IDX_W'(7);
  localparam logic [7:0]            BANK_FIXED_RST = 8'd1;
  localparam logic [BANK_IDX_W-1:0] BANK_PRG_A     = BANK_IDX_W'(6);
  localparam logic [BANK_IDX_W-1:0] BANK_PRG_B     = BANK_IDX_W'(7);

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] address;
    logic [7:0]  data;
  } in_t;

  typedef struct packed {
    logic [2:0]  target;
    logic [18:0] mem_address;
    logic        write_enable;
    logic [7:0]  write_data;
    logic        irq_request;
    logic        mirror_horizontal;
  } out_t;

  typedef struct packed {
    logic       start;
    logic [7:0] dividend;
    logic [8:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] rem;
  } mod_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CALC,
    S_DIV,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

@@ hw/rtl/bank_switch_mapper_with_scanline_irq.sv @@
// Top level of the bank switch mapper with scanline interrupt counter.
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+-------------------------
//  in      | in        | in_valid/in_stall  | in_word  (in_t)
//  out     | out       | out_valid/out_stall| out_word (out_t)
//  cfg     | in        | cfg_we             | cfg_index, cfg_data
//
// One word at a time. Accept, bank RAM read, compute, hand-over: the steps
// for most words; a pattern ROM read with a nonzero bank count adds a pass
// through the remainder unit before the hand-over.
// The output register lets the next word be accepted while a result waits.
// Synchronous reset; bank entries not yet written read their reset value.
`default_nettype none
module bank_switch_mapper_with_scanline_irq import bsm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire in_t        in_word,
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      out_t       out_word,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [5:0] cfg_data
);

  state_t state, state_next;
  in_t    cur;
  out_t   res;
  out_t   calc;

  logic [5:0] prg_units;
  logic [5:0] chr_units;
  logic       chr_ram;

  logic [7:0] bank_sel;
  logic       mirror;
  logic [7:0] irq_load_val;
  logic [7:0] irq_count;
  logic       irq_on;
  logic       irq_rearm;

  logic [BANK_N-1:0]     vld;
  logic [BANK_IDX_W-1:0] ridx;
  logic [BANK_IDX_W-1:0] rd_idx;
  logic [7:0]            ram_rdata;
  logic                  ram_we;
  logic [7:0]            bank_val;

  logic [12:0] p;
  logic [2:0]  slot;
  logic [7:0]  banks8;
  logic [7:0]  sel;
  logic [7:0]  win_bank;
  logic [20:0] prg_full;
  logic [7:0]  pat_bank;
  logic [8:0]  pat_banks;
  logic        need_div;
  logic        port_hit;
  logic [15:0] port;

  logic [7:0] irq_count_next;
  logic       mirror_next;
  logic       load_out;

  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  function automatic logic [18:0] chr_addr(input logic [7:0] bank, input logic [9:0] lo);
    logic [19:0] full;
    full = {2'b00, bank, lo} & CHR_MASK;
    return full[18:0];
  endfunction

  bsm_ram #(.WIDTH(8), .DEPTH(BANK_N)) u_bank_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (bank_sel[BANK_IDX_W-1:0]),
    .wdata (cur.data),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  bsm_chr_mod u_chr_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  // pattern slot and bank index to read
  always_comb begin
    p    = cur.address[12:0] ^ {bank_sel[7], 12'b0};
    slot = p[12:10];
    if (cur.action == ACT_CHR_RD) begin
      rd_idx = slot[2] ? BANK_IDX_W'(slot - 3'd2) : BANK_IDX_W'({2'b00, slot[1]});
    end else begin
      rd_idx = (cur.address[14:13] == 2'b01) ? BANK_PRG_B : BANK_PRG_A;
    end
  end

  // datapath of the compute step
  always_comb begin
    bank_val = vld[ridx] ? ram_rdata : ((ridx == BANK_FIXED_IDX) ? BANK_FIXED_RST : 8'd0);

    banks8 = {1'b0, prg_units, 1'b0};
    sel    = banks8 - 8'd1;
    case (cur.address[14:13])
      2'd0:    win_bank = bank_sel[6] ? 8'(banks8 - 8'd2) : (bank_val & sel);
      2'd1:    win_bank = bank_val & sel;
      2'd2:    win_bank = bank_sel[6] ? (bank_val & sel) : 8'(banks8 - 8'd2);
      default: win_bank = sel;
    endcase
    prg_full = {win_bank, cur.address[12:0]} & PRG_MASK;

    pat_bank  = slot[2] ? bank_val : {bank_val[7:1], slot[0]};
    pat_banks = {chr_units, 3'b000};

    port     = cur.address & PORT_MASK;
    port_hit = (cur.action == ACT_PRG_WR) && (cur.address >= PRG_ROM_BASE);

    mirror_next = mirror;
    if (port_hit && port == PORT_MIRROR) begin
      mirror_next = cur.data[0];
    end

    if (irq_count == 8'd0 || irq_rearm) begin
      irq_count_next = irq_load_val;
    end else begin
      irq_count_next = irq_count - 8'd1;
    end

    need_div = 1'b0;
    calc     = '0;
    calc.mirror_horizontal = mirror_next;
    case (cur.action)
      ACT_PRG_RD: begin
        if (cur.address >= PRG_ROM_BASE) begin
          calc.target      = TGT_PRG_ROM;
          calc.mem_address = prg_full[18:0];
        end else if (cur.address >= PRG_RAM_BASE) begin
          calc.target      = TGT_PRG_RAM;
          calc.mem_address = 19'(cur.address - PRG_RAM_BASE);
        end
      end
      ACT_PRG_WR: begin
        if (!port_hit && cur.address >= PRG_RAM_BASE) begin
          calc.target       = TGT_PRG_RAM;
          calc.mem_address  = 19'(cur.address - PRG_RAM_BASE);
          calc.write_enable = 1'b1;
          calc.write_data   = cur.data;
        end
      end
      ACT_CHR_RD: begin
        if (chr_ram) begin
          calc.target      = TGT_CHR_RAM;
          calc.mem_address = {6'b0, cur.address[12:0]};
        end else begin
          calc.target      = TGT_CHR_ROM;
          calc.mem_address = chr_addr(pat_bank, cur.address[9:0]);
          need_div         = (pat_banks != 9'd0);
        end
      end
      ACT_CHR_WR: begin
        if (chr_ram) begin
          calc.target       = TGT_CHR_RAM;
          calc.mem_address  = {6'b0, cur.address[12:0]};
          calc.write_enable = 1'b1;
          calc.write_data   = cur.data;
        end
      end
      ACT_TICK: begin
        calc.irq_request = (irq_count_next == 8'd0) && irq_on;
      end
      ACT_NT: begin
        calc.target = TGT_NT_RAM;
        calc.mem_address = mirror ? {8'b0, cur.address[11], cur.address[9:0]}
                                  : {8'b0, cur.address[10:0]};
      end
      default: begin
        calc = '0;
        calc.mirror_horizontal = mirror_next;
      end
    endcase
  end

  // control
  always_comb begin
    state_next       = state;
    in_stall         = 1'b1;
    ram_we           = 1'b0;
    load_out         = 1'b0;
    mod_req.start    = 1'b0;
    mod_req.dividend = pat_bank;
    mod_req.divisor  = pat_banks;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_CALC;
      end
      S_CALC: begin
        ram_we = port_hit && (port == PORT_BANK);
        if (need_div) begin
          mod_req.start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DIV: begin
        if (mod_rsp.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // mapper and configuration state
  always_ff @(posedge clk) begin
    if (rst) begin
      prg_units    <= 6'd2;
      chr_units    <= 6'd1;
      chr_ram      <= 1'b0;
      bank_sel     <= '0;
      mirror       <= 1'b0;
      irq_load_val <= '0;
      irq_count    <= '0;
      irq_on       <= 1'b0;
      irq_rearm    <= 1'b0;
      vld          <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PRG_UNITS: prg_units <= cfg_data;
          CFG_CHR_UNITS: chr_units <= cfg_data;
          CFG_CHR_RAM:   chr_ram   <= cfg_data[0];
          default: ;
        endcase
      end
      if (state == S_CALC) begin
        mirror <= mirror_next;
        if (ram_we) begin
          vld[bank_sel[BANK_IDX_W-1:0]] <= 1'b1;
        end
        if (cur.action == ACT_TICK) begin
          irq_count <= irq_count_next;
          irq_rearm <= 1'b0;
        end
        if (port_hit) begin
          case (port)
            PORT_SELECT:  bank_sel     <= cur.data;
            PORT_LATCH:   irq_load_val <= cur.data;
            PORT_RELOAD: begin
              irq_count <= '0;
              irq_rearm <= 1'b1;
            end
            PORT_IRQ_OFF: irq_on <= 1'b0;
            PORT_IRQ_ON:  irq_on <= 1'b1;
            default: ;
          endcase
        end
      end
    end
  end

  // word capture and result holding
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cur <= in_word;
    end
    if (state == S_READ) begin
      ridx <= rd_idx;
    end
    if (state == S_CALC) begin
      res <= calc;
    end
    if (state == S_DIV && mod_rsp.done) begin
      res.mem_address <= chr_addr(mod_rsp.rem, cur.address[9:0]);
    end
    if (load_out) begin
      out_word <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    mod_rsp.done |-> state == S_DIV)
    else $error("remainder done outside divide state");

  a_ram_we_port: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (cur.action == ACT_PRG_WR) && (cur.address >= PRG_ROM_BASE))
    else $error("bank RAM written by a non-port word");

  a_we_target: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.write_enable |->
      (out_word.target == TGT_PRG_RAM) || (out_word.target == TGT_CHR_RAM))
    else $error("write enable on a read-only target");

  a_irq_none: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.irq_request |-> out_word.target == TGT_NONE)
    else $error("interrupt request with a memory target");

endmodule
`default_nettype wire

@@ hw/rtl/bsm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hw/rtl/bsm_chr_mod.sv @@
// Restoring remainder unit for pattern bank reduction, one dividend bit a cycle.
`default_nettype none
module bsm_chr_mod import bsm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mod_req_t req,
  output      mod_rsp_t rsp
);

  logic       busy;
  logic       finished;
  logic [2:0] cnt;
  logic [7:0] sh;
  logic [7:0] r;
  logic [8:0] div;
  logic [8:0] trial;
  logic [7:0] r_next;

  always_comb begin
    trial  = {r, sh[7]};
    r_next = (trial >= div) ? 8'(trial - div) : trial[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      cnt      <= '0;
      finished <= 1'b0;
    end else begin
      finished <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd7) begin
          busy     <= 1'b0;
          finished <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      sh  <= req.dividend;
      div <= req.divisor;
      r   <= '0;
    end else if (busy) begin
      sh <= {sh[6:0], 1'b0};
      r  <= r_next;
    end
  end

  assign rsp = '{done: finished, rem: r};

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking bank switch mapper testbench: directed and random words against a predictor.
module testbench;
  import bsm_pkg::*;

  localparam logic [2:0] ACT_SPARE_A  = 3'd6;
  localparam logic [2:0] ACT_SPARE_B  = 3'd7;
  localparam logic [1:0] CFG_SPARE    = 2'd3;
  localparam int         DRAIN_CYCLES = 20;
  localparam int         STALL_LIMIT  = 2000;
  localparam int         HOLD_CYCLES  = 120;
  localparam int         RAND_PER_SET = 200;
  localparam int         N_SETS       = 8;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_t        in_word = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_t       out_word;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_PRG_UNITS;
  logic [5:0] cfg_data = '0;

  bank_switch_mapper_with_scanline_irq dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mapper state as seen by the predictor
  int unsigned prg_units, chr_units;
  logic        chr_ram;
  logic [7:0]  bank_sel;
  logic [7:0]  bank_r [8];
  logic        mirror;
  logic [7:0]  irq_load_val, irq_cnt;
  logic        irq_en, irq_rearm;

  in_t  pending_words[$];
  out_t expected_results[$];
  int   errors = 0;
  int   quiet_cycles = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   word_taken = 1'b0;
  bit   pressure_go = 1'b0;
  bit   pressure_done = 1'b0;
  int   hold_left = 0;
  int   pushed = 0;

  task automatic mapper_reset();
    prg_units = 2;
    chr_units = 1;
    chr_ram = 1'b0;
    bank_sel = '0;
    foreach (bank_r[i]) bank_r[i] = '0;
    bank_r[7] = 8'd1;
    mirror = 1'b0;
    irq_load_val = '0;
    irq_cnt = '0;
    irq_en = 1'b0;
    irq_rearm = 1'b0;
  endtask

  function automatic int unsigned prg_rom_byte(logic [15:0] a);
    int unsigned banks, msk, bank;
    banks = prg_units * 2;
    msk = banks - 1;
    case (a[14:13])
      2'd0: bank = bank_sel[6] ? banks - 2 : (32'(bank_r[6]) & msk);
      2'd1: bank = 32'(bank_r[7]) & msk;
      2'd2: bank = bank_sel[6] ? (32'(bank_r[6]) & msk) : banks - 2;
      default: bank = banks - 1;
    endcase
    return ((bank << 13) | (32'(a) & 32'h1FFF)) & ((32'd1 << PRG_ADDR_BITS) - 32'd1);
  endfunction

  function automatic int unsigned chr_rom_byte(logic [15:0] a);
    int unsigned banks, p, slot, bank;
    banks = chr_units * 8;
    p = 32'(a) & 32'h1FFF;
    if (bank_sel[7]) p = p ^ 32'h1000;
    slot = p >> 10;
    if (slot < 4) bank = (32'(bank_r[slot >> 1]) & 32'hFE) + (slot & 1);
    else bank = 32'(bank_r[slot - 2]);
    if (banks != 0) bank = bank % banks;
    return ((bank << 10) | (32'(a) & 32'h3FF)) & ((32'd1 << CHR_ADDR_BITS) - 32'd1);
  endfunction

  function automatic void port_write(logic [15:0] a, logic [7:0] v);
    case (a & PORT_MASK)
      PORT_SELECT:  bank_sel = v;
      PORT_BANK:    bank_r[bank_sel[2:0]] = v;
      PORT_MIRROR:  mirror = v[0];
      PORT_LATCH:   irq_load_val = v;
      PORT_RELOAD:  begin
        irq_cnt = '0;
        irq_rearm = 1'b1;
      end
      PORT_IRQ_OFF: irq_en = 1'b0;
      PORT_IRQ_ON:  irq_en = 1'b1;
      default: ;
    endcase
  endfunction

  // advances the mapper state by one bus word and returns the translated access
  function automatic out_t mapper_predict(in_t w);
    out_t        o;
    int unsigned n;
    o = '0;
    case (w.action)
      ACT_PRG_RD: begin
        if (w.address >= PRG_ROM_BASE) begin
          o.target = TGT_PRG_ROM;
          o.mem_address = 19'(prg_rom_byte(w.address));
        end else if (w.address >= PRG_RAM_BASE) begin
          o.target = TGT_PRG_RAM;
          o.mem_address = 19'(w.address - PRG_RAM_BASE);
        end
      end
      ACT_PRG_WR: begin
        if (w.address >= PRG_ROM_BASE) begin
          port_write(w.address, w.data);
        end else if (w.address >= PRG_RAM_BASE) begin
          o.target = TGT_PRG_RAM;
          o.mem_address = 19'(w.address - PRG_RAM_BASE);
          o.write_enable = 1'b1;
          o.write_data = w.data;
        end
      end
      ACT_CHR_RD: begin
        if (chr_ram) begin
          o.target = TGT_CHR_RAM;
          o.mem_address = 19'(w.address & 16'h1FFF);
        end else begin
          o.target = TGT_CHR_ROM;
          o.mem_address = 19'(chr_rom_byte(w.address));
        end
      end
      ACT_CHR_WR: begin
        if (chr_ram) begin
          o.target = TGT_CHR_RAM;
          o.mem_address = 19'(w.address & 16'h1FFF);
          o.write_enable = 1'b1;
          o.write_data = w.data;
        end
      end
      ACT_TICK: begin
        if (irq_cnt == 0 || irq_rearm) begin
          irq_cnt = irq_load_val;
          irq_rearm = 1'b0;
        end else begin
          irq_cnt = irq_cnt - 8'd1;
        end
        o.irq_request = (irq_cnt == 0) && irq_en;
      end
      ACT_NT: begin
        n = 32'(w.address) & 32'h0FFF;
        o.target = TGT_NT_RAM;
        if (mirror) o.mem_address = 19'((n & 32'h3FF) | (n[11] ? 32'h400 : 32'h0));
        else o.mem_address = 19'(n & 32'h7FF);
      end
      default: ;
    endcase
    o.mirror_horizontal = mirror;
    return o;
  endfunction

  task automatic note_mismatch(string field, int unsigned want_v, int unsigned got_v);
    errors++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want_v, got_v);
  endtask

  always @(negedge clk) begin : word_drv
    bit offer;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !word_taken)) begin
      offer = pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct;
      if (offer) begin
        in_word <= pending_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : stall_drv
    bit nxt;
    if (hold_left > 0) begin
      hold_left--;
      nxt = 1'b1;
    end else if (pressure_go && !pressure_done) begin
      pressure_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      nxt = 1'b1;
    end else begin
      nxt = $urandom_range(99) < recv_stall_pct;
    end
    out_stall <= nxt;
  end

  always @(posedge clk) begin : bus_mon
    out_t want;
    bit   moved;
    if (rst) begin
      word_taken = 1'b0;
      quiet_cycles = 0;
    end else begin
      moved = 1'b0;
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected word %p", $time, out_word);
        end else begin
          want = expected_results.pop_front();
          if (out_word.target !== want.target)
            note_mismatch("target", want.target, out_word.target);
          if (out_word.mem_address !== want.mem_address)
            note_mismatch("mem_address", want.mem_address, out_word.mem_address);
          if (out_word.write_enable !== want.write_enable)
            note_mismatch("write_enable", want.write_enable, out_word.write_enable);
          if (out_word.write_data !== want.write_data)
            note_mismatch("write_data", want.write_data, out_word.write_data);
          if (out_word.irq_request !== want.irq_request)
            note_mismatch("irq_request", want.irq_request, out_word.irq_request);
          if (out_word.mirror_horizontal !== want.mirror_horizontal)
            note_mismatch("mirror_horizontal", want.mirror_horizontal,
                          out_word.mirror_horizontal);
        end
      end
      word_taken = in_valid && !in_stall;
      if (word_taken) begin
        moved = 1'b1;
        expected_results.push_back(mapper_predict(in_word));
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic put(logic [2:0] act, logic [15:0] a, logic [7:0] d);
    pending_words.push_back(in_t'{action: act, address: a, data: d});
    pushed++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [5:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      CFG_PRG_UNITS: prg_units = v;
      CFG_CHR_UNITS: chr_units = v;
      CFG_CHR_RAM:   chr_ram = v[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_idling(idle_mode_t m);
    case (m)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 57; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 57; end
      default:   begin send_idle_pct = 8;  recv_stall_pct = 8;  end
    endcase
  endtask

  function automatic logic [15:0] port_addr(logic [15:0] port);
    return port | (16'($urandom()) & 16'h1FFE);
  endfunction

  task automatic random_read();
    case ($urandom_range(5))
      0: put(ACT_PRG_RD, 16'($urandom_range(16'h8000, 16'hFFFF)), 8'($urandom()));
      1: put(ACT_PRG_RD, 16'($urandom()), 8'($urandom()));
      2: put(ACT_CHR_RD, 16'($urandom()), 8'($urandom()));
      3: put(ACT_CHR_WR, 16'($urandom()), 8'($urandom()));
      4: put(ACT_NT, 16'($urandom()), 8'($urandom()));
      default: put(ACT_PRG_WR, 16'($urandom_range(16'h6000, 16'h7FFF)), 8'($urandom()));
    endcase
  endtask

  task automatic random_words(int count);
    int stop;
    stop = pushed + count;
    while (pushed < stop) begin
      case ($urandom_range(9))
        0, 1: begin
          put(ACT_PRG_WR, port_addr(PORT_SELECT), 8'($urandom()));
          put(ACT_PRG_WR, port_addr(PORT_BANK),
              $urandom_range(3) == 0 ? 8'hFF : 8'($urandom()));
          repeat ($urandom_range(1, 3)) random_read();
        end
        2: begin
          put(ACT_PRG_WR, port_addr(PORT_LATCH),
              $urandom_range(3) == 0 ? 8'($urandom()) : 8'($urandom_range(4)));
          if ($urandom_range(1)) put(ACT_PRG_WR, port_addr(PORT_RELOAD), 8'($urandom()));
          put(ACT_PRG_WR, port_addr($urandom_range(3) == 0 ? PORT_IRQ_OFF : PORT_IRQ_ON),
              8'($urandom()));
          repeat ($urandom_range(2, 8)) begin
            put(ACT_TICK, 16'($urandom()), 8'($urandom()));
            if ($urandom_range(3) == 0) random_read();
          end
        end
        3: begin
          put(ACT_PRG_WR, port_addr(PORT_MIRROR), 8'($urandom()));
          repeat ($urandom_range(1, 3)) put(ACT_NT, 16'($urandom()), 8'($urandom()));
        end
        4, 5, 6, 7: random_read();
        8: put(ACT_PRG_WR, 16'($urandom_range(16'h8000, 16'hFFFF)), 8'($urandom()));
        default: put(3'($urandom()), 16'($urandom()), 8'($urandom()));
      endcase
    end
  endtask

  task automatic directed_words();
    put(ACT_PRG_RD, 16'h0000, 8'h00);
    put(ACT_PRG_RD, 16'h6000, 8'hFF);
    put(ACT_PRG_RD, 16'h7FFF, 8'h00);
    put(ACT_PRG_RD, 16'h8000, 8'h00);
    put(ACT_PRG_RD, 16'hFFFF, 8'h00);
    put(ACT_PRG_WR, 16'h6123, 8'hA5);
    put(ACT_PRG_WR, 16'h5FFF, 8'hFF);
    put(ACT_PRG_WR, PORT_SELECT, 8'hC7);
    put(ACT_PRG_WR, PORT_BANK, 8'hFF);
    put(ACT_PRG_RD, 16'hA000, 8'h00);
    put(ACT_PRG_RD, 16'hC000, 8'h00);
    put(ACT_CHR_RD, 16'h0000, 8'h00);
    put(ACT_CHR_RD, 16'hFFFF, 8'h00);
    put(ACT_CHR_WR, 16'h0400, 8'h5A);
    put(ACT_PRG_WR, PORT_MIRROR, 8'h01);
    put(ACT_NT, 16'h2C05, 8'h00);
    put(ACT_NT, 16'hFFFF, 8'h00);
    put(ACT_PRG_WR, 16'hA001, 8'hFF);  // RAM protect, no effect
    put(ACT_PRG_WR, PORT_LATCH, 8'h02);
    put(ACT_PRG_WR, PORT_RELOAD, 8'h00);
    put(ACT_PRG_WR, PORT_IRQ_ON, 8'h00);
    repeat (4) put(ACT_TICK, 16'h0000, 8'h00);
    put(ACT_PRG_WR, PORT_IRQ_OFF, 8'h00);
    put(ACT_TICK, 16'hFFFF, 8'hFF);
    put(ACT_SPARE_A, 16'hFFFF, 8'hFF);
    put(ACT_SPARE_B, 16'h8000, 8'hFF);
  endtask

  // bank sizes per set, zero and odd sizes included
  int prg_set [N_SETS] = '{2, 1, 32, 8, 0, 63, 3, 16};
  int chr_set [N_SETS] = '{1, 1, 32, 5, 0, 63, 17, 3};
  int ram_set [N_SETS] = '{0, 0, 0, 1, 0, 0, 1, 0};

  initial begin
    mapper_reset();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int s = 0; s < N_SETS; s++) begin
      if (s != 0) begin
        wait_drained();
        if (s == N_SETS - 1) write_reg(CFG_SPARE, 6'h3F);
        write_reg(CFG_PRG_UNITS, 6'(prg_set[s]));
        write_reg(CFG_CHR_UNITS, 6'(chr_set[s]));
        write_reg(CFG_CHR_RAM, 6'(ram_set[s]));
      end
      set_idling(idle_mode_t'(s % 4));
      if (s == 4) pressure_go = 1'b1;
      if (s == 0) directed_words();
      random_words(RAND_PER_SET);
    end
    wait_drained();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
